// ===== rtl/particle_mesh_gravity_step_assert.svh =====
// Assertion macros for the particle-mesh gravity step block.
// Both macros expect clk and arst_n in scope.
`ifndef PARTICLE_MESH_GRAVITY_STEP_ASSERT_SVH
`define PARTICLE_MESH_GRAVITY_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define PMG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define PMG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PMG_ASSERT(label, prop, msg)
`define PMG_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/pmg_pkg.sv =====
`timescale 1ns / 1ps
package pmg_pkg;

	localparam int GRID_SIDE     = 128;
	localparam int MAX_PARTICLES = 512;
	localparam int CELLS         = GRID_SIDE * GRID_SIDE;
	localparam int CELL_W        = $clog2(CELLS);
	localparam int CIDX_W        = $clog2(GRID_SIDE);
	localparam int PIDX_W        = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int PCNT_W        = $clog2(MAX_PARTICLES + 1);
	localparam int DENS_W        = 10;
	localparam int CFG_W         = 31;

	localparam logic [DENS_W-1:0] DENS_MAX = '1;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_STEP = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic RK_READ = 1'b0;
	localparam logic RK_STEP = 1'b1;

	localparam logic [1:0] CFG_SOURCE = 2'd0;
	localparam logic [1:0] CFG_TSTEP  = 2'd1;
	localparam logic [1:0] CFG_SWEEPS = 2'd2;
	localparam logic [1:0] CFG_PCOUNT = 2'd3;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [8:0]         particle_index;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
	} pmg_cmd_t;

	typedef struct packed {
		logic               result_kind;
		logic [8:0]         out_index;
		logic signed [31:0] out_pos_x;
		logic signed [31:0] out_pos_y;
		logic signed [31:0] out_vel_x;
		logic signed [31:0] out_vel_y;
	} pmg_rsp_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
	} pmg_part_t;

	typedef struct packed {
		logic              ok;
		logic [CIDX_W-1:0] idx;
	} pmg_cell_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		if (v < 64'shFFFF_FFFF_8000_0000)
			return 32'sh8000_0000;
		return $signed(v[31:0]);
	endfunction

	// nearest cell, round half up; ok only for interior cells
	function automatic pmg_cell_t cell_of(input logic signed [31:0] p);
		logic [32:0] t;
		logic [16:0] c;
		pmg_cell_t   r;
		t = {p[31], p} + 33'h0_8000;
		c = t[32:16];
		r.ok = !c[16] && (c != 17'd0) && (c[15:0] <= 16'(GRID_SIDE - 2));
		r.idx = c[CIDX_W-1:0];
		return r;
	endfunction

	function automatic logic [CELL_W-1:0] cell_addr(input logic [CIDX_W-1:0] cx,
			input logic [CIDX_W-1:0] cy);
		return CELL_W'(CELL_W'(cx) * CELL_W'(GRID_SIDE) + CELL_W'(cy));
	endfunction

endpackage

// ===== rtl/pmg_kick.sv =====
`timescale 1ns / 1ps
// Four-stage kick-drift for one axis: v += f*dt, then p += v*dt.
module pmg_kick (
	input  logic               clk,
	input  logic signed [32:0] frc,
	input  logic signed [31:0] vel,
	input  logic signed [31:0] pos,
	input  logic [16:0]        dt,
	output logic signed [31:0] vel_new,
	output logic signed [31:0] pos_new
);

	logic signed [50:0] fdt_s1;
	logic signed [31:0] vel_s1, pos_s1;
	logic signed [31:0] vel_s2, pos_s2;
	logic signed [49:0] vdt_s3;
	logic signed [31:0] vel_s3, pos_s3;
	logic signed [31:0] vel_s4, pos_s4;

	always_ff @(posedge clk) begin
		fdt_s1 <= frc * $signed({1'b0, dt});
		vel_s1 <= vel;
		pos_s1 <= pos;
		vel_s2 <= pmg_pkg::sat32(64'(vel_s1) + 64'(fdt_s1 >>> 16));
		pos_s2 <= pos_s1;
		vdt_s3 <= vel_s2 * $signed({1'b0, dt});
		vel_s3 <= vel_s2;
		pos_s3 <= pos_s2;
		pos_s4 <= pmg_pkg::sat32(64'(pos_s3) + 64'(vdt_s3 >>> 16));
		vel_s4 <= vel_s3;
	end

	assign vel_new = vel_s4;
	assign pos_new = pos_s4;

endmodule

// ===== rtl/particle_mesh_gravity_step.sv =====
`timescale 1ns / 1ps
// Particle-mesh gravity step, Q16.16, nearest-grid-point deposit and
// Gauss-Seidel Poisson relaxation on a GRID_SIDE square mesh.
// Command channel (cmd_valid/cmd_ready/cmd): load writes one particle slot,
// read returns one slot, step runs one full time step. Response channel
// (rsp_valid/rsp_ready/rsp) carries read data or the step-done item.
// A read item appears on rsp the cycle after acceptance, and the next command
// is taken as soon as the response register is empty or being taken. A
// stalled response holds the command channel off, since the particle memory
// read port feeds rsp directly. A step runs density clear over all CELLS,
// deposit per particle, relaxation over the interior cells for each sweep
// (one potential memory read port, four neighbours per cell), then force and
// kick per particle; its pace is set by the potential memory's one read port.
// After reset a clearing pass zeroes the potential and density memories; no
// command is taken until it ends. Configuration writes are taken in any
// cycle and should be made only while idle.
`include "particle_mesh_gravity_step_assert.svh"
module particle_mesh_gravity_step (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  pmg_pkg::pmg_cmd_t              cmd,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output pmg_pkg::pmg_rsp_t              rsp,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [pmg_pkg::CFG_W-1:0]      cfg_wdata
);

	localparam int CELL_W = pmg_pkg::CELL_W;
	localparam int CIDX_W = pmg_pkg::CIDX_W;
	localparam int PIDX_W = pmg_pkg::PIDX_W;
	localparam int PCNT_W = pmg_pkg::PCNT_W;
	localparam int DENS_W = pmg_pkg::DENS_W;
	localparam int GS     = pmg_pkg::GRID_SIDE;

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DCLR  = 3'd2;
	localparam logic [2:0] ST_DEP   = 3'd3;
	localparam logic [2:0] ST_SWEEP = 3'd4;
	localparam logic [2:0] ST_FORCE = 3'd5;

	// configuration
	logic [30:0] src_q;
	logic [16:0] dt_q;
	logic [7:0]  sweeps_q;
	logic [9:0]  pcount_q;

	// control
	logic [2:0]        state_q;
	logic [3:0]        ph_q;
	logic [CELL_W-1:0] cell_q;
	logic [PCNT_W-1:0] k_q;
	logic [CIDX_W-1:0] ix_q, iy_q;
	logic [7:0]        sw_q;
	logic              rsp_valid_q, rsp_kind_q, rsp_zero_q;
	logic [8:0]        rsp_idx_q;

	// datapath
	logic [CELL_W-1:0]  dc_q, fc_q;
	logic               dint_q, fint_q;
	logic signed [33:0] acc_q;
	logic [40:0]        prod_q;
	logic signed [31:0] phi_c_q, phi_xp_q, phi_yp_q;

	// memories
	pmg_pkg::pmg_part_t pmem [pmg_pkg::MAX_PARTICLES];
	logic signed [31:0] phi  [pmg_pkg::CELLS];
	logic [DENS_W-1:0]  dens [pmg_pkg::CELLS];

	pmg_pkg::pmg_part_t pmem_rdata, pmem_wdata;
	logic               pmem_re, pmem_we;
	logic [PIDX_W-1:0]  pmem_raddr, pmem_waddr;
	logic signed [31:0] phi_rdata, phi_wdata;
	logic               phi_re, phi_we;
	logic [CELL_W-1:0]  phi_raddr, phi_waddr;
	logic [DENS_W-1:0]  dens_rdata, dens_wdata;
	logic               dens_re, dens_we;
	logic [CELL_W-1:0]  dens_raddr, dens_waddr;

	logic               accept, idx_ok, k_lt_n;
	logic [PCNT_W-1:0]  n_eff;
	pmg_pkg::pmg_cell_t cpx, cpy;
	logic [CELL_W-1:0]  p_addr, sw_c;
	logic               p_int;
	logic signed [42:0] sw_diff;
	logic signed [31:0] sw_new;
	logic signed [32:0] fx, fy;
	logic signed [31:0] vx_new, vy_new, px_new, py_new;

	assign cmd_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = cmd_valid && cmd_ready;
	assign idx_ok    = 32'(cmd.particle_index) < pmg_pkg::MAX_PARTICLES;
	assign n_eff     = (32'(pcount_q) > pmg_pkg::MAX_PARTICLES)
		? PCNT_W'(pmg_pkg::MAX_PARTICLES) : PCNT_W'(pcount_q);
	assign k_lt_n    = k_q < n_eff;

	// cell of the particle just read from the particle memory
	assign cpx    = pmg_pkg::cell_of(pmem_rdata.pos_x);
	assign cpy    = pmg_pkg::cell_of(pmem_rdata.pos_y);
	assign p_addr = pmg_pkg::cell_addr(cpx.idx, cpy.idx);
	assign p_int  = cpx.ok && cpy.ok;

	// relaxation: phi = floor((sum of neighbours - source*count) / 4)
	assign sw_c    = pmg_pkg::cell_addr(ix_q, iy_q);
	assign sw_diff = 43'(acc_q) - $signed({2'b00, prod_q});
	assign sw_new  = pmg_pkg::sat32(64'(sw_diff >>> 2));

	// forward-difference force; exterior particles feel none
	assign fx = fint_q ? (33'(phi_c_q) - 33'(phi_xp_q)) : 33'sd0;
	assign fy = fint_q ? (33'(phi_c_q) - 33'(phi_yp_q)) : 33'sd0;

	pmg_kick u_kick_x (
		.clk     (clk),
		.frc     (fx),
		.vel     (pmem_rdata.vel_x),
		.pos     (pmem_rdata.pos_x),
		.dt      (dt_q),
		.vel_new (vx_new),
		.pos_new (px_new)
	);

	pmg_kick u_kick_y (
		.clk     (clk),
		.frc     (fy),
		.vel     (pmem_rdata.vel_y),
		.pos     (pmem_rdata.pos_y),
		.dt      (dt_q),
		.vel_new (vy_new),
		.pos_new (py_new)
	);

	// memory port steering
	always_comb begin
		pmem_re    = 1'b0;
		pmem_raddr = k_q[PIDX_W-1:0];
		pmem_we    = 1'b0;
		pmem_waddr = k_q[PIDX_W-1:0];
		pmem_wdata = '{pos_x: px_new, pos_y: py_new, vel_x: vx_new, vel_y: vy_new};
		phi_re     = 1'b0;
		phi_raddr  = sw_c;
		phi_we     = 1'b0;
		phi_waddr  = cell_q;
		phi_wdata  = '0;
		dens_re    = 1'b0;
		dens_raddr = sw_c;
		dens_we    = 1'b0;
		dens_waddr = cell_q;
		dens_wdata = '0;
		case (state_q)
			ST_INIT: begin
				phi_we  = 1'b1;
				dens_we = 1'b1;
			end
			ST_IDLE: begin
				if (accept && cmd.opcode == pmg_pkg::OP_LOAD && idx_ok) begin
					pmem_we    = 1'b1;
					pmem_waddr = PIDX_W'(cmd.particle_index);
					pmem_wdata = '{pos_x: cmd.pos_x, pos_y: cmd.pos_y,
						vel_x: cmd.vel_x, vel_y: cmd.vel_y};
				end
				if (accept && cmd.opcode == pmg_pkg::OP_READ && idx_ok) begin
					pmem_re    = 1'b1;
					pmem_raddr = PIDX_W'(cmd.particle_index);
				end
			end
			ST_DCLR: dens_we = 1'b1;
			ST_DEP: begin
				case (ph_q)
					4'd0: pmem_re = k_lt_n;
					4'd1: begin
						dens_re    = 1'b1;
						dens_raddr = p_addr;
					end
					4'd2: begin
						dens_we    = dint_q && (dens_rdata != pmg_pkg::DENS_MAX);
						dens_waddr = dc_q;
						dens_wdata = dens_rdata + 1'b1;
					end
					default: ;
				endcase
			end
			ST_SWEEP: begin
				case (ph_q)
					4'd0: begin
						phi_re    = 1'b1;
						phi_raddr = sw_c + CELL_W'(GS);
						dens_re   = 1'b1;
					end
					4'd1: begin
						phi_re    = 1'b1;
						phi_raddr = sw_c - CELL_W'(GS);
					end
					4'd2: begin
						phi_re    = 1'b1;
						phi_raddr = sw_c + 1'b1;
					end
					4'd3: begin
						phi_re    = 1'b1;
						phi_raddr = sw_c - 1'b1;
					end
					4'd5: begin
						phi_we    = 1'b1;
						phi_waddr = sw_c;
						phi_wdata = sw_new;
					end
					default: ;
				endcase
			end
			ST_FORCE: begin
				case (ph_q)
					4'd0: pmem_re = k_lt_n;
					4'd1: begin
						phi_re    = 1'b1;
						phi_raddr = p_addr;
					end
					4'd2: begin
						phi_re    = 1'b1;
						phi_raddr = fc_q + CELL_W'(GS);
					end
					4'd3: begin
						phi_re    = 1'b1;
						phi_raddr = fc_q + 1'b1;
					end
					4'd9: pmem_we = 1'b1;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pmem_we)
			pmem[pmem_waddr] <= pmem_wdata;
		if (pmem_re)
			pmem_rdata <= pmem[pmem_raddr];
	end

	always_ff @(posedge clk) begin
		if (phi_we)
			phi[phi_waddr] <= phi_wdata;
		if (phi_re)
			phi_rdata <= phi[phi_raddr];
	end

	always_ff @(posedge clk) begin
		if (dens_we)
			dens[dens_waddr] <= dens_wdata;
		if (dens_re)
			dens_rdata <= dens[dens_raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q    <= 31'd65536;
			dt_q     <= 17'd6554;
			sweeps_q <= 8'd50;
			pcount_q <= 10'd500;
		end else if (cfg_we) begin
			case (cfg_index)
				pmg_pkg::CFG_SOURCE: src_q    <= cfg_wdata[30:0];
				pmg_pkg::CFG_TSTEP:  dt_q     <= cfg_wdata[16:0];
				pmg_pkg::CFG_SWEEPS: sweeps_q <= cfg_wdata[7:0];
				pmg_pkg::CFG_PCOUNT: pcount_q <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			ph_q        <= '0;
			cell_q      <= '0;
			k_q         <= '0;
			ix_q        <= CIDX_W'(1);
			iy_q        <= CIDX_W'(1);
			sw_q        <= '0;
			rsp_valid_q <= 1'b0;
			rsp_kind_q  <= pmg_pkg::RK_READ;
			rsp_zero_q  <= 1'b0;
			rsp_idx_q   <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				ST_INIT: begin
					cell_q <= cell_q + 1'b1;
					if (cell_q == CELL_W'(pmg_pkg::CELLS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept && cmd.opcode == pmg_pkg::OP_STEP) begin
						state_q <= ST_DCLR;
						cell_q  <= '0;
					end
					if (accept && cmd.opcode == pmg_pkg::OP_READ) begin
						rsp_valid_q <= 1'b1;
						rsp_kind_q  <= pmg_pkg::RK_READ;
						rsp_idx_q   <= cmd.particle_index;
						rsp_zero_q  <= !idx_ok;
					end
				end
				ST_DCLR: begin
					cell_q <= cell_q + 1'b1;
					if (cell_q == CELL_W'(pmg_pkg::CELLS - 1)) begin
						state_q <= ST_DEP;
						k_q     <= '0;
						ph_q    <= '0;
					end
				end
				ST_DEP: begin
					case (ph_q)
						4'd0: begin
							if (k_lt_n)
								ph_q <= 4'd1;
							else if (sweeps_q == 8'd0) begin
								state_q <= ST_FORCE;
								k_q     <= '0;
							end else begin
								state_q <= ST_SWEEP;
								ix_q    <= CIDX_W'(1);
								iy_q    <= CIDX_W'(1);
								sw_q    <= '0;
							end
						end
						4'd1: begin
							dc_q   <= p_addr;
							dint_q <= p_int;
							ph_q   <= 4'd2;
						end
						default: begin
							k_q  <= k_q + 1'b1;
							ph_q <= 4'd0;
						end
					endcase
				end
				ST_SWEEP: begin
					case (ph_q)
						4'd0: ph_q <= 4'd1;
						4'd1: begin
							acc_q  <= 34'(phi_rdata);
							prod_q <= 41'(src_q) * 41'(dens_rdata);
							ph_q   <= 4'd2;
						end
						4'd2, 4'd3, 4'd4: begin
							acc_q <= acc_q + 34'(phi_rdata);
							ph_q  <= ph_q + 1'b1;
						end
						default: begin
							// advance y inner, x outer, then the sweep count
							ph_q <= 4'd0;
							if (iy_q != CIDX_W'(GS - 2))
								iy_q <= iy_q + 1'b1;
							else begin
								iy_q <= CIDX_W'(1);
								if (ix_q != CIDX_W'(GS - 2))
									ix_q <= ix_q + 1'b1;
								else begin
									ix_q <= CIDX_W'(1);
									sw_q <= sw_q + 1'b1;
									if (sw_q == sweeps_q - 1'b1) begin
										state_q <= ST_FORCE;
										k_q     <= '0;
									end
								end
							end
						end
					endcase
				end
				ST_FORCE: begin
					case (ph_q)
						4'd0: begin
							if (k_lt_n)
								ph_q <= 4'd1;
							else begin
								state_q     <= ST_IDLE;
								rsp_valid_q <= 1'b1;
								rsp_kind_q  <= pmg_pkg::RK_STEP;
								rsp_idx_q   <= '0;
								rsp_zero_q  <= 1'b1;
							end
						end
						4'd1: begin
							fc_q   <= p_addr;
							fint_q <= p_int;
							ph_q   <= 4'd2;
						end
						4'd2: begin
							phi_c_q <= phi_rdata;
							ph_q    <= 4'd3;
						end
						4'd3: begin
							phi_xp_q <= phi_rdata;
							ph_q     <= 4'd4;
						end
						4'd4: begin
							phi_yp_q <= phi_rdata;
							ph_q     <= 4'd5;
						end
						4'd9: begin
							// kick result written back this cycle
							k_q  <= k_q + 1'b1;
							ph_q <= 4'd0;
						end
						default: ph_q <= ph_q + 1'b1;
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// response: read data comes straight from the particle memory read register
	assign rsp_valid       = rsp_valid_q;
	assign rsp.result_kind = rsp_kind_q;
	assign rsp.out_index   = rsp_idx_q;
	assign rsp.out_pos_x   = rsp_zero_q ? 32'sd0 : pmem_rdata.pos_x;
	assign rsp.out_pos_y   = rsp_zero_q ? 32'sd0 : pmem_rdata.pos_y;
	assign rsp.out_vel_x   = rsp_zero_q ? 32'sd0 : pmem_rdata.vel_x;
	assign rsp.out_vel_y   = rsp_zero_q ? 32'sd0 : pmem_rdata.vel_y;

	`PMG_ASSERT_NEXT(a_step_starts_clear, accept && cmd.opcode == pmg_pkg::OP_STEP, state_q == ST_DCLR, "step item did not start density clear")
	`PMG_ASSERT(a_pmem_wr_phase, pmem_we |-> (state_q == ST_IDLE || state_q == ST_FORCE), "particle write outside load or force")
	`PMG_ASSERT(a_phi_wr_phase, phi_we |-> (state_q == ST_INIT || state_q == ST_SWEEP), "potential write outside clear or sweep")
	`PMG_ASSERT(a_busy_holds_cmd, (state_q != ST_IDLE) |-> !cmd_ready, "command taken while busy")

endmodule
